FILE: rtl/core/tws_pkg.sv
`timescale 1ns / 1ps

package tws_pkg;

  // sample and field widths
  localparam int SW      = 16;
  localparam int GAIN_W  = 15;
  localparam int IDX_W   = 10;
  localparam int CFG_W   = 15;
  localparam int IN_W    = 80;   // 74 payload bits, padded to whole bytes
  localparam int OUT_W   = 16;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int CRED_W     = 4;

  // item kinds (tuser)
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SHAPE = 1'b1;

  // register indexes
  localparam logic REG_GAIN = 1'b0;
  localparam logic REG_MODE = 1'b1;

  localparam logic [GAIN_W-1:0]   GAIN_RST  = 15'd16384;
  localparam logic signed [SW-1:0] THIRD_Q15 = 16'sd10922;  // ~1/3 in Q0.15

  typedef logic signed [SW-1:0] sample_t;

  typedef struct packed {
    logic [SW-1:0] shaped;
    logic          last;
  } res_t;

  // clamp to the signed sample range
  function automatic sample_t sat_sample(input logic signed [19:0] v);
    if (v > 20'sd32767) begin
      return 16'sh7fff;
    end else if (v < -20'sd32768) begin
      return -16'sh8000;
    end
    return v[SW-1:0];
  endfunction

endpackage

FILE: rtl/core/table_waveshaper_interp.sv
`timescale 1ns / 1ps
// Pipeline: input word -> P -> I -> R -> M -> D -> result queue -> output stream;
//   a table write is issued from the I stage and commits into the table from there.
// Throughput: write words and single-mode shape words 1 per cycle while credits remain;
//   a triple-mode word holds the I stage for three lookups, as each lookup uses both read ports.
// Reset: config, valids, pointers and credits clear asynchronously; the table is not
//   cleared and reads back undefined until an entry is written.
module table_waveshaper_interp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // config write port
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [tws_pkg::CFG_W-1:0]  cfg_data_i,
  // input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata, low bit up: entry_index[10], entry_value[16], sample_a[16],
  //   sample_b[16], sample_c[16], zero pad[6]
  input  logic [tws_pkg::IN_W-1:0]   s_axis_tdata,
  input  logic                       s_axis_tuser,   // op
  input  logic                       s_axis_tlast,   // block_end
  // output stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [tws_pkg::OUT_W-1:0]  m_axis_tdata,   // shaped[16]
  output logic                       m_axis_tlast    // block_last
);
  import tws_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = SW + AW;                       // width of table position
  localparam logic [PW-1:0] DEPTH_V = PW'(TABLE_DEPTH);
  localparam logic [AW-1:0] TOP_IDX = AW'(TABLE_DEPTH - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0] gain_q;
  logic              mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RST;
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN: gain_q <= cfg_data_i[GAIN_W-1:0];
        REG_MODE: mode_q <= cfg_data_i[0];
        default:  ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input word unpack
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0] in_idx;
  sample_t          in_val, in_a, in_b, in_c;
  logic             in_acc, shape_acc, in_wok;

  assign in_idx = s_axis_tdata[9:0];
  assign in_val = s_axis_tdata[25:10];
  assign in_a   = s_axis_tdata[41:26];
  assign in_b   = s_axis_tdata[57:42];
  assign in_c   = s_axis_tdata[73:58];
  assign in_wok = int'(in_idx) < TABLE_DEPTH;   // out-of-range writes are dropped

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign shape_acc = in_acc && (s_axis_tuser == OP_SHAPE);

  // ---------------------------------------------------------------------------
  // Credits: shape words taken but not yet popped from the result queue.
  // Keeps the queue from overflowing so the pipeline never stalls.
  // ---------------------------------------------------------------------------
  logic [CRED_W-1:0] cred_q, cred_d;
  logic              credit_ok, pop;

  assign credit_ok = cred_q < CRED_W'(FIFO_DEPTH);

  always_comb begin
    cred_d = cred_q;
    if (shape_acc && !pop) begin
      cred_d = cred_q + CRED_W'(1);
    end else if (!shape_acc && pop) begin
      cred_d = cred_q - CRED_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cred_q <= '0;
    end else begin
      cred_q <= cred_d;
    end
  end

  // ---------------------------------------------------------------------------
  // P stage: holding register, gain multiply for single mode
  // ---------------------------------------------------------------------------
  logic          p_valid_q, p_op_q, p_wen_q, p_last_q;
  logic [AW-1:0] p_waddr_q;
  sample_t       p_wdata_q, p_a_q, p_b_q, p_c_q;
  logic          p_take, i_take, i_final;

  logic signed [31:0] gain_prod;
  sample_t            x_gain;

  assign gain_prod = 32'(p_a_q) * 32'($signed({1'b0, gain_q}));
  assign x_gain    = sat_sample(20'((gain_prod + 32'sd16384) >>> 15));

  assign p_take        = p_valid_q && i_take;
  assign s_axis_tready = (!p_valid_q || i_take) && credit_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= in_acc || (p_valid_q && !i_take);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p_op_q    <= s_axis_tuser;
      p_wen_q   <= in_wok;
      p_waddr_q <= AW'(in_idx);
      p_wdata_q <= in_val;
      p_a_q     <= in_a;
      p_b_q     <= in_b;
      p_c_q     <= in_c;
      p_last_q  <= s_axis_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // I stage: issue one lookup per cycle (1 or 3 lanes), or one table write
  // ---------------------------------------------------------------------------
  logic          i_valid_q, i_op_q, i_wen_q, i_avg_q, i_last_q;
  logic [AW-1:0] i_waddr_q;
  sample_t       i_wdata_q;
  sample_t       i_x_q [3];
  logic [1:0]    i_cnt_q, i_nm1_q;

  assign i_final = (i_cnt_q == i_nm1_q);
  assign i_take  = !i_valid_q || i_final;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_valid_q <= 1'b0;
      i_cnt_q   <= '0;
    end else begin
      i_valid_q <= p_take || (i_valid_q && !i_final);
      if (p_take) begin
        i_cnt_q <= '0;
      end else if (i_valid_q && !i_final) begin
        i_cnt_q <= i_cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_take) begin
      i_op_q    <= p_op_q;
      i_wen_q   <= p_wen_q;
      i_waddr_q <= p_waddr_q;
      i_wdata_q <= p_wdata_q;
      i_last_q  <= p_last_q;
      i_avg_q   <= mode_q;
      i_nm1_q   <= (p_op_q == OP_SHAPE && mode_q) ? 2'd2 : 2'd0;
      i_x_q[0]  <= mode_q ? p_a_q : x_gain;
      i_x_q[1]  <= p_b_q;
      i_x_q[2]  <= p_c_q;
    end
  end

  // sample -> table position: (x + 1) * DEPTH / 2 in units of 2^-16
  sample_t       lane_x;
  logic [SW-1:0] lane_u;
  logic [PW-1:0] lane_pos;
  logic [AW-1:0] idx_i, idx_j;
  logic [SW-1:0] lane_f;
  logic          lane_rd, mem_we;

  assign lane_x   = i_x_q[i_cnt_q];
  assign lane_u   = {~lane_x[SW-1], lane_x[SW-2:0]};
  assign lane_pos = PW'(lane_u) * DEPTH_V;
  assign idx_i    = lane_pos[PW-1:SW];
  assign lane_f   = lane_pos[SW-1:0];
  assign idx_j    = (idx_i == TOP_IDX) ? idx_i : idx_i + AW'(1);  // clamp, no wrap

  assign lane_rd = i_valid_q && (i_op_q == OP_SHAPE);
  assign mem_we  = i_valid_q && (i_op_q == OP_WRITE) && i_wen_q;

  // Table: one write port, two read ports, registered reads. Writes and reads
  // issue from the same stage in word order, so no forwarding is needed.
  sample_t shape_table_q [TABLE_DEPTH];
  sample_t rd_i_q, rd_j_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      shape_table_q[i_waddr_q] <= i_wdata_q;
    end
    if (lane_rd) begin
      rd_i_q <= shape_table_q[idx_i];
      rd_j_q <= shape_table_q[idx_j];
    end
  end

  // ---------------------------------------------------------------------------
  // R stage: table data back; form the two weighted products
  // ---------------------------------------------------------------------------
  logic          r_valid_q, r_first_q, r_llane_q, r_avg_q, r_last_q;
  logic [SW-1:0] r_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else begin
      r_valid_q <= lane_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lane_rd) begin
      r_f_q     <= lane_f;
      r_first_q <= (i_cnt_q == 2'd0);
      r_llane_q <= i_final;
      r_avg_q   <= i_avg_q;
      r_last_q  <= i_last_q;
    end
  end

  logic [SW:0]        w0;
  logic signed [33:0] prod0;
  logic signed [32:0] prod1;

  assign w0    = 17'h10000 - {1'b0, r_f_q};
  assign prod0 = 34'(rd_i_q) * 34'($signed({1'b0, w0}));
  assign prod1 = 33'(rd_j_q) * 33'($signed({1'b0, r_f_q}));

  // ---------------------------------------------------------------------------
  // M stage: products registered; round, saturate, accumulate lanes
  // ---------------------------------------------------------------------------
  logic               m_valid_q, m_first_q, m_llane_q, m_avg_q, m_last_q;
  logic signed [33:0] m_p0_q;
  logic signed [32:0] m_p1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= r_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_valid_q) begin
      m_p0_q    <= prod0;
      m_p1_q    <= prod1;
      m_first_q <= r_first_q;
      m_llane_q <= r_llane_q;
      m_avg_q   <= r_avg_q;
      m_last_q  <= r_last_q;
    end
  end

  logic signed [34:0] interp;
  sample_t            lane_y;
  logic signed [17:0] acc_q, acc_sum;

  assign interp  = 35'(m_p0_q) + 35'(m_p1_q) + 35'sd32768;
  assign lane_y  = sat_sample(20'(interp >>> 16));
  assign acc_sum = (m_first_q ? 18'sd0 : acc_q) + 18'(lane_y);

  always_ff @(posedge clk_i) begin
    if (m_valid_q) begin
      acc_q <= acc_sum;
    end
  end

  // ---------------------------------------------------------------------------
  // D stage: sum of lanes; triple mode scales by ~1/3
  // ---------------------------------------------------------------------------
  logic               d_valid_q, d_avg_q, d_last_q;
  logic signed [17:0] d_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else begin
      d_valid_q <= m_valid_q && m_llane_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_valid_q && m_llane_q) begin
      d_sum_q  <= acc_sum;
      d_avg_q  <= m_avg_q;
      d_last_q <= m_last_q;
    end
  end

  logic signed [32:0] avg_prod;
  sample_t            d_res;

  assign avg_prod = 33'(d_sum_q) * 33'(THIRD_Q15);
  assign d_res    = d_avg_q ? sat_sample(20'((avg_prod + 33'sd16384) >>> 15))
                            : d_sum_q[SW-1:0];

  // ---------------------------------------------------------------------------
  // Result queue; its head drives the output stream
  // ---------------------------------------------------------------------------
  res_t               fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CRED_W-1:0]  fifo_cnt_q;
  logic               push;
  res_t               head;

  assign push          = d_valid_q;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = (fifo_cnt_q != '0);
  assign m_axis_tdata  = head.shaped;
  assign m_axis_tlast  = head.last;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{shaped: d_res, last: d_last_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      if (push && !pop) begin
        fifo_cnt_q <= fifo_cnt_q + CRED_W'(1);
      end else if (!push && pop) begin
        fifo_cnt_q <= fifo_cnt_q - CRED_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cred_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cred_q <= CRED_W'(FIFO_DEPTH))
    else $error("credit count above queue depth");

  a_cred_covers_fifo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cred_q >= fifo_cnt_q)
    else $error("queued results exceed outstanding credits");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_cnt_q < CRED_W'(FIFO_DEPTH)))
    else $error("result pushed into full queue");

  a_lane_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    i_valid_q |-> (i_cnt_q <= i_nm1_q))
    else $error("lane counter ran past lane count");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import tws_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int SETTLE      = 20;      // margin past the deepest pipeline, in cycles
  localparam int LIMIT       = 400000;  // watchdog, cycles
  localparam int RAND_ITEMS  = 200;
  localparam int N_PHASES    = 5;
  localparam int HOLD_CYCLES = 400;     // long receiver hold-off
  localparam int HOLD_AT     = 40;      // random words sent before the hold-off starts

  // mode register values
  localparam logic MODE_SINGLE = 1'b0;
  localparam logic MODE_TRIPLE = 1'b1;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_SHAPE,
    ROW_SET_GAIN,
    ROW_SET_MODE
  } row_kind_e;

  // one row of the directed table; want is used only when typed is set
  typedef struct {
    row_kind_e        kind;
    logic [IDX_W-1:0] idx;
    sample_t          val;
    sample_t          a;
    sample_t          b;
    sample_t          c;
    logic             blk_end;
    logic             typed;
    sample_t          want;
  } row_t;

  typedef struct {
    sample_t shaped;
    logic    last;
  } shaped_word_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = REG_GAIN;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             s_axis_tuser = OP_WRITE;
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;

  table_waveshaper_interp u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a mirror of the transfer table and of both registers.
  // The table is fully preloaded before any shape word, so no unwritten entry
  // is ever looked up.
  // ---------------------------------------------------------------------------
  sample_t             wave_table [DEPTH];
  logic [GAIN_W-1:0]   gain_m = GAIN_RST;
  logic                mode_m = MODE_SINGLE;

  shaped_word_t        shaped_q [$];   // expected output words, oldest first

  // driver side hints for directed rows with a typed-in answer
  logic                cur_typed = 1'b0;
  sample_t             cur_want = '0;

  // bookkeeping
  int                  failures = 0;
  int                  n_writes = 0;
  int                  n_checked = 0;
  int                  n_stall = 0;
  int                  n_settings = 0;
  int                  rand_sent = 0;
  int                  cycles = 0;
  bit                  quiet = 1'b0;    // no idling on either side while set

  function automatic sample_t clip16(longint v);
    if (v > 32767) begin
      return 16'sh7fff;
    end else if (v < -32768) begin
      return 16'sh8000;
    end
    return v[SW-1:0];
  endfunction

  // Map x to position (x+1)*DEPTH/2, split into index and 16-bit fraction,
  // blend the two neighbours. The upper neighbour clamps at the top entry.
  function automatic longint table_interp(longint x);
    longint u, p, i, j, f, s;
    u = longint'(clip16(x)) + 32768;
    p = u * DEPTH;
    i = p >> SW;
    f = p & 65535;
    if (i > DEPTH - 1) begin
      i = DEPTH - 1;
    end
    j = (i + 1 > DEPTH - 1) ? DEPTH - 1 : i + 1;
    s = longint'(wave_table[i]) * (65536 - f) + longint'(wave_table[j]) * f + 32768;
    return longint'(clip16(s >>> SW));
  endfunction

  // Single mode: gain first (round half up), then one lookup.
  // Triple mode: three lookups, sum times 10922/32768, rounded and clamped.
  function automatic sample_t shaped_for(sample_t a, sample_t b, sample_t c);
    longint x, sum;
    if (mode_m == MODE_SINGLE) begin
      x = (longint'(a) * longint'(gain_m) + 16384) >>> 15;
      return clip16(table_interp(x));
    end
    sum = table_interp(a) + table_interp(b) + table_interp(c);
    return clip16((sum * longint'(THIRD_Q15) + 16384) >>> 15);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: input acceptance feeds the predictor, output acceptance is
  // compared with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : mon
    shaped_word_t w;
    if (s_axis_tvalid && s_axis_tready) begin
      if (s_axis_tuser == OP_WRITE) begin
        // tlast is don't-care on a write
        wave_table[s_axis_tdata[9:0]] = s_axis_tdata[25:10];
        n_writes++;
      end else begin
        w.shaped = cur_typed ? cur_want
                             : shaped_for(s_axis_tdata[41:26], s_axis_tdata[57:42],
                                          s_axis_tdata[73:58]);
        w.last   = s_axis_tlast;
        shaped_q = {shaped_q, w};
      end
    end
    if (s_axis_tvalid && !s_axis_tready) begin
      n_stall++;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (shaped_q.size() == 0) begin
        $display("%0t: output word with nothing expected, expected none actual %0d",
                 $time, $signed(m_axis_tdata));
        failures++;
      end else begin
        w = shaped_q.pop_front();
        n_checked++;
        if (m_axis_tdata !== w.shaped) begin
          $display("%0t: shaped mismatch, expected %0d actual %0d",
                   $time, w.shaped, $signed(m_axis_tdata));
          failures++;
        end
        if (m_axis_tlast !== w.last) begin
          $display("%0t: block_last mismatch, expected %0b actual %0b",
                   $time, w.last, m_axis_tlast);
          failures++;
        end
      end
    end
  end

  // Receiver: random backpressure, one long hold-off counted here, and a
  // quiet stretch with tready pinned high.
  always @(negedge clk_i) begin : rx
    int  hold_left;
    bit  hold_done;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && rand_sent >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 23);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("table_waveshaper_interp test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic sample_t rand_sample();
    case ($urandom_range(19))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return 16'shffff;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic row_t mk_row(row_kind_e kind, logic [IDX_W-1:0] idx, sample_t val,
                                  sample_t a, sample_t b, sample_t c, logic blk_end,
                                  logic typed, sample_t want);
    row_t r;
    r.kind    = kind;
    r.idx     = idx;
    r.val     = val;
    r.a       = a;
    r.b       = b;
    r.c       = c;
    r.blk_end = blk_end;
    r.typed   = typed;
    r.want    = want;
    return r;
  endfunction

  // Offer one word, with random gaps in front; returns at the accepting edge.
  task automatic send_word(logic op, logic [IDX_W-1:0] idx, sample_t val, sample_t a,
                           sample_t b, sample_t c, logic blk_end, logic typed,
                           sample_t want);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tlast  <= blk_end;
    // pad[6], sample_c, sample_b, sample_a, entry_value, entry_index
    s_axis_tdata  <= {6'b0, c, b, a, val, idx};
    cur_typed     <= typed;
    cur_want      <= want;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Register write: only once all results are out and the last table write
  // has had time to commit.
  task automatic set_reg(logic idx, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (shaped_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx == REG_GAIN) begin
      gain_m = value[GAIN_W-1:0];
    end else begin
      mode_m = value[0];
    end
    n_settings++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random word: ~30% table writes (often landing on entries being read),
  // the rest shape words; edges of the index range show up often.
  task automatic rand_item();
    logic             op;
    logic [IDX_W-1:0] idx;
    op = ($urandom_range(99) < 30) ? OP_WRITE : OP_SHAPE;
    case ($urandom_range(9))
      0:       idx = '0;
      1:       idx = 10'd1023;
      2:       idx = 10'd1022;
      default: idx = IDX_W'($urandom);
    endcase
    send_word(op, idx, rand_sample(), rand_sample(), rand_sample(), rand_sample(),
              1'($urandom), 1'b0, '0);
    rand_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    row_t              rows [$];
    int                k;
    int                ph;
    logic [GAIN_W-1:0] g;
    logic              m;

    // Directed table. Typed answers only where the blend is exact: the index lands
    // on one entry (fraction zero) or both neighbours clamp to the same entry.
    // reset gain (0.5): lowest sample lands on entry 256
    rows = {rows, mk_row(ROW_WRITE, 10'd256, 16'sh1234, 0, 0, 0, 1'b0, 1'b0, 0)};
    rows = {rows, mk_row(ROW_SHAPE, 0, 0, 16'sh8000, 0, 0, 1'b1, 1'b1, 16'sh1234)};
    // extremes at both ends of the table; tlast set on a write is ignored
    rows = {rows, mk_row(ROW_WRITE, 10'd1023, 16'sh7fff, 0, 0, 0, 1'b0, 1'b0, 0)};
    rows = {rows, mk_row(ROW_WRITE, 10'd1022, 16'sh8000, 0, 0, 0, 1'b0, 1'b0, 0)};
    rows = {rows, mk_row(ROW_WRITE, 10'd0, 16'sh8000, 0, 0, 0, 1'b1, 1'b0, 0)};
    rows = {rows, mk_row(ROW_WRITE, 10'd1, 16'sh7fff, 0, 0, 0, 1'b0, 1'b0, 0)};
    rows = {rows, mk_row(ROW_WRITE, 10'd512, -16'sd12345, 0, 0, 0, 1'b0, 1'b0, 0)};
    // zero gain: every sample hits the center entry
    rows = {rows, mk_row(ROW_SET_GAIN, 0, 16'sh0000, 0, 0, 0, 1'b0, 1'b0, 0)};
    rows = {rows, mk_row(ROW_SHAPE, 0, 0, 16'sh7fff, 0, 0, 1'b0, 1'b1, -16'sd12345)};
    // full gain: top sample sits past entry 1023, neighbour clamps (no wrap)
    rows = {rows, mk_row(ROW_SET_GAIN, 0, 16'sh7fff, 0, 0, 0, 1'b0, 1'b0, 0)};
    rows = {rows, mk_row(ROW_SHAPE, 0, 0, 16'sh7fff, 0, 0, 1'b0, 1'b1, 16'sh7fff)};
    rows = {rows, mk_row(ROW_SHAPE, 0, 0, 16'sh8000, 0, 0, 1'b0, 1'b0, 0)};
    rows = {rows, mk_row(ROW_SHAPE, 0, 0, 16'sh0000, 0, 0, 1'b0, 1'b1, -16'sd12345)};
    rows = {rows, mk_row(ROW_SHAPE, 0, 0, 16'shffff, 0, 0, 1'b0, 1'b0, 0)};
    rows = {rows, mk_row(ROW_SHAPE, 0, 0, 16'sh4000, 0, 0, 1'b1, 1'b0, 0)};
    // read right behind a write to the same entry
    rows = {rows, mk_row(ROW_WRITE, 10'd600, 16'sd777, 0, 0, 0, 1'b0, 1'b0, 0)};
    rows = {rows, mk_row(ROW_SHAPE, 0, 0, 16'sd5632, 0, 0, 1'b0, 1'b0, 0)};
    // triple mode, sample extremes
    rows = {rows, mk_row(ROW_SET_MODE, 0, 16'(MODE_TRIPLE), 0, 0, 0, 1'b0, 1'b0, 0)};
    rows = {rows, mk_row(ROW_SHAPE, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 1'b0, 0)};
    rows = {rows, mk_row(ROW_SHAPE, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1, 1'b0, 0)};
    rows = {rows, mk_row(ROW_SHAPE, 0, 0, 16'sh8000, 16'sh0000, 16'sh7fff, 1'b0, 1'b0, 0)};
    rows = {rows, mk_row(ROW_SET_MODE, 0, 16'(MODE_SINGLE), 0, 0, 0, 1'b0, 1'b0, 0)};
    rows = {rows, mk_row(ROW_SET_GAIN, 0, 16'(GAIN_RST), 0, 0, 0, 1'b0, 1'b0, 0)};

    // reset, released on a falling edge away from the rising edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // preload every entry so that no lookup reads an unwritten one
    for (k = 0; k < DEPTH; k++) begin
      send_word(OP_WRITE, IDX_W'(k), rand_sample(), rand_sample(), rand_sample(),
                rand_sample(), 1'($urandom), 1'b0, '0);
    end

    foreach (rows[k]) begin
      case (rows[k].kind)
        ROW_WRITE: begin
          send_word(OP_WRITE, rows[k].idx, rows[k].val, rows[k].a, rows[k].b, rows[k].c,
                    rows[k].blk_end, 1'b0, '0);
        end
        ROW_SHAPE: begin
          send_word(OP_SHAPE, rows[k].idx, rows[k].val, rows[k].a, rows[k].b, rows[k].c,
                    rows[k].blk_end, rows[k].typed, rows[k].want);
        end
        ROW_SET_GAIN: set_reg(REG_GAIN, CFG_W'(rows[k].val[GAIN_W-1:0]));
        default:      set_reg(REG_MODE, CFG_W'(rows[k].val[0]));
      endcase
    end

    // random phases: both modes, gain at 0, full scale and random
    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       begin g = GAIN_W'($urandom_range(32767)); m = MODE_SINGLE; end
        1:       begin g = 15'h7fff;                       m = MODE_TRIPLE; end
        2:       begin g = '0;                             m = MODE_SINGLE; end
        3:       begin g = 15'h7fff;                       m = MODE_SINGLE; end
        default: begin g = GAIN_W'($urandom_range(32767)); m = MODE_TRIPLE; end
      endcase
      set_reg(REG_GAIN, CFG_W'(g));
      set_reg(REG_MODE, CFG_W'(m));
      repeat (RAND_ITEMS / N_PHASES) begin
        rand_item();
        // quiet window: neither side idles
        quiet = (rand_sent >= 100 && rand_sent < 180);
      end
    end

    // drain
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    quiet = 1'b0;
    while (shaped_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    if (shaped_q.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, shaped_q.size());
      failures++;
    end

    $display("Run covered %0d table writes and %0d checked output words over %0d register writes,",
             n_writes, n_checked, n_settings);
    $display("both modes with gain at zero, full scale and random; input stalled %0d cycles.",
             n_stall);
    if (failures == 0) begin
      $display("table_waveshaper_interp test passed");
    end else begin
      $display("table_waveshaper_interp test failed");
    end
    $finish;
  end

endmodule
